### sv/ise_pkg.sv
// ise_pkg: shared types and constants for the INI section extractor.
// Used by ise_front, ise_cmdq, ise_back and the top level.
package ise_pkg;

    localparam int LINE_MAX_DEF = 63;
    localparam int NAME_MAX_DEF = 8;
    localparam int CNT_W        = 8;    // holds a line count up to 255
    localparam int CMDQ_DEPTH   = 4;
    localparam int OUTQ_DEPTH   = 4;

    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_RBR = 8'h5D;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic CFG_IDX_NAME_BYTES  = 1'b0;
    localparam logic CFG_IDX_NAME_LENGTH = 1'b1;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    typedef enum logic [1:0] {
        MODE_SEARCH,
        MODE_COPY,
        MODE_DONE
    } t_mode;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_BYTES
    } t_seq;

    typedef enum logic {
        CMD_LINE,
        CMD_DONE
    } t_kind;

    // work handed from front to back
    typedef struct packed {
        t_kind            kind;
        logic             held_valid;
        logic [7:0]       held_term;
        logic [CNT_W-1:0] count;
        logic             bank;
        logic [1:0]       status;
    } t_cmd;

    // line buffer write port
    typedef struct packed {
        logic             we;
        logic             bank;
        logic [CNT_W-1:0] idx;
        logic [7:0]       data;
    } t_wr;

    // bank release from back to front
    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_byte;
        logic       is_done;
        logic [1:0] status;
        logic       last;
    } t_res;

endpackage

### sv/ise_front.sv
// ise_front: accepts file bytes, tracks lines, matches the section header,
// writes content bytes to the line buffer and queues commands. Uses ise_pkg.
module ise_front import ise_pkg::*; #(
    parameter int LINE_MAX = LINE_MAX_DEF,
    parameter int NAME_MAX = NAME_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_marker,
    input  logic        i_cmdq_full,
    input  t_rel        i_rel,
    output t_wr         o_wr,
    output logic        o_cmd_push,
    output t_cmd        o_cmd
);

    localparam int FW = $clog2(LINE_MAX + 12);

    logic [63:0]   r_name_bytes;
    logic [3:0]    r_name_len;
    t_mode         r_mode,       n_mode;
    logic [FW-1:0] r_fill,       n_fill;
    logic          r_first_ob,   n_first_ob;
    logic [7:0]    r_prev,       n_prev;
    logic [7:0]    r_held_term,  n_held_term;
    logic          r_held_valid, n_held_valid;
    logic          r_ovf,        n_ovf;
    logic          r_name_ok,    n_name_ok;
    logic          r_wbank,      n_wbank;
    logic [1:0]    r_busy,       n_busy;

    logic [3:0]    name_cap;
    logic [3:0]    name_eff;
    logic [FW-1:0] fill_m1;
    logic [7:0]    name_byte;
    logic          accept;
    logic          is_term;
    logic          header;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_bytes <= '0;
            r_name_len   <= 4'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_NAME_BYTES:  r_name_bytes <= i_cfg_data;
                CFG_IDX_NAME_LENGTH: r_name_len   <= i_cfg_data[3:0];
            endcase
        end
    end

    // effective name length: clamp, then stop at the first zero byte
    always_comb begin
        name_cap = (r_name_len > 4'(NAME_MAX)) ? 4'(NAME_MAX) : r_name_len;
        name_eff = name_cap;
        for (int i = 7; i >= 0; i--) begin
            if (4'(i) < name_cap && r_name_bytes[8*i +: 8] == CH_NUL) begin
                name_eff = 4'(i);
            end
        end
    end

    assign fill_m1   = r_fill - FW'(1);
    assign name_byte = r_name_bytes[8*fill_m1[2:0] +: 8];
    assign o_full    = i_cmdq_full || (r_mode == MODE_COPY && r_busy[r_wbank]);
    assign accept    = i_push && !o_full;
    assign is_term   = (i_data_byte == CH_NL) || (i_data_byte == CH_NUL);
    assign header    = r_first_ob && (r_prev == CH_RBR);

    always_comb begin
        n_mode       = r_mode;
        n_fill       = r_fill;
        n_first_ob   = r_first_ob;
        n_prev       = r_prev;
        n_held_term  = r_held_term;
        n_held_valid = r_held_valid;
        n_ovf        = r_ovf;
        n_name_ok    = r_name_ok;
        n_wbank      = r_wbank;
        n_busy       = r_busy;
        o_wr         = '0;
        o_cmd_push   = 1'b0;
        o_cmd        = '0;

        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end

        if (accept && r_mode != MODE_DONE) begin
            if (i_end_marker) begin
                o_cmd_push   = 1'b1;
                o_cmd.kind   = CMD_DONE;
                o_cmd.status = (r_mode == MODE_SEARCH) ? ST_NOT_FOUND : ST_FOUND;
                n_mode       = MODE_DONE;
            end else if (!is_term) begin
                if (r_fill == '0) begin
                    n_first_ob = (i_data_byte == CH_LBR);
                end
                if (r_mode == MODE_SEARCH) begin
                    if (r_fill != '0 && r_fill <= FW'(name_eff) && i_data_byte != name_byte) begin
                        n_name_ok = 1'b0;
                    end
                end else if (r_fill < FW'(LINE_MAX)) begin
                    o_wr.we   = 1'b1;
                    o_wr.bank = r_wbank;
                    o_wr.idx  = CNT_W'(r_fill);
                    o_wr.data = i_data_byte;
                end else begin
                    n_ovf = 1'b1;
                end
                if (r_fill != '1) begin
                    n_fill = r_fill + FW'(1);
                end
                n_prev = i_data_byte;
            end else begin
                if (r_mode == MODE_SEARCH) begin
                    if (header && name_eff != 4'd0 && r_name_ok
                            && r_fill == FW'(name_eff) + FW'(2)) begin
                        n_mode       = MODE_COPY;
                        n_held_valid = 1'b0;
                    end
                end else if (header) begin
                    o_cmd_push   = 1'b1;
                    o_cmd.kind   = CMD_DONE;
                    o_cmd.status = ST_FOUND;
                    n_mode       = MODE_DONE;
                end else if (r_ovf) begin
                    o_cmd_push   = 1'b1;
                    o_cmd.kind   = CMD_DONE;
                    o_cmd.status = ST_TOO_LONG;
                    n_mode       = MODE_DONE;
                end else begin
                    // line complete: hand it to the back end, swap banks
                    o_cmd_push       = 1'b1;
                    o_cmd.kind       = CMD_LINE;
                    o_cmd.held_valid = r_held_valid;
                    o_cmd.held_term  = r_held_term;
                    o_cmd.count      = CNT_W'(r_fill);
                    o_cmd.bank       = r_wbank;
                    n_busy[r_wbank]  = 1'b1;
                    n_wbank          = ~r_wbank;
                    n_held_term      = i_data_byte;
                    n_held_valid     = 1'b1;
                end
                n_fill     = '0;
                n_first_ob = 1'b0;
                n_ovf      = 1'b0;
                n_name_ok  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SEARCH;
            r_fill       <= '0;
            r_first_ob   <= 1'b0;
            r_prev       <= '0;
            r_held_term  <= '0;
            r_held_valid <= 1'b0;
            r_ovf        <= 1'b0;
            r_name_ok    <= 1'b1;
            r_wbank      <= 1'b0;
            r_busy       <= '0;
        end else begin
            r_mode       <= n_mode;
            r_fill       <= n_fill;
            r_first_ob   <= n_first_ob;
            r_prev       <= n_prev;
            r_held_term  <= n_held_term;
            r_held_valid <= n_held_valid;
            r_ovf        <= n_ovf;
            r_name_ok    <= n_name_ok;
            r_wbank      <= n_wbank;
            r_busy       <= n_busy;
        end
    end

endmodule

### sv/ise_cmdq.sv
// ise_cmdq: small command FIFO between front and back.
// Uses ise_pkg for t_cmd and CMDQ_DEPTH.
module ise_cmdq import ise_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd          r_q [CMDQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### sv/ise_back.sv
// ise_back: two-bank line buffer, emit sequencer and result queue.
// Carries out line and done commands from ise_cmdq. Uses ise_pkg.
module ise_back import ise_pkg::*; #(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_wr        i_wr,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output t_rel       o_rel,
    output logic       o_empty,
    input  logic       i_pop,
    output t_res       o_res
);

    localparam int AW  = $clog2(LINE_MAX);
    localparam int PW  = $clog2(OUTQ_DEPTH);
    localparam int OCW = $clog2(OUTQ_DEPTH + 1);

    logic [7:0]     r_mem [2**(AW+1)];
    logic [7:0]     r_mem_q;
    logic [AW:0]    rd_addr;

    t_seq           r_seq, n_seq;
    logic [AW-1:0]  r_idx, n_idx;

    logic           r_s1_valid, r_s1_mem;
    t_res           r_s1_res;
    logic           iss, iss_mem;
    t_res           iss_res;
    logic           can_issue;
    logic           last_idx;

    t_res           r_oq [OUTQ_DEPTH];
    logic [PW-1:0]  r_ow, r_or;
    logic [OCW-1:0] r_ocnt;
    logic           opop;
    t_res           s1_out;

    assign rd_addr = {i_cmd.bank, r_idx};

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[{i_wr.bank, i_wr.idx[AW-1:0]}] <= i_wr.data;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    // room for the stage in flight plus the one issued now
    assign can_issue = (r_ocnt + OCW'(r_s1_valid)) < OCW'(OUTQ_DEPTH);
    assign last_idx  = (CNT_W'(r_idx) + CNT_W'(1)) == i_cmd.count;

    always_comb begin
        n_seq     = r_seq;
        n_idx     = r_idx;
        iss       = 1'b0;
        iss_mem   = 1'b0;
        iss_res   = '0;
        o_cmd_pop = 1'b0;
        o_rel     = '0;
        unique case (r_seq)
            SEQ_IDLE: begin
                if (i_cmd_valid && can_issue) begin
                    if (i_cmd.kind == CMD_DONE) begin
                        iss            = 1'b1;
                        iss_res.is_done = 1'b1;
                        iss_res.status = i_cmd.status;
                        iss_res.last   = 1'b1;
                        o_cmd_pop      = 1'b1;
                    end else begin
                        if (i_cmd.held_valid) begin
                            iss              = 1'b1;
                            iss_res.out_byte = i_cmd.held_term;
                            iss_res.is_byte  = 1'b1;
                            iss_res.last     = (i_cmd.count == '0);
                        end
                        if (i_cmd.count == '0) begin
                            o_cmd_pop   = 1'b1;
                            o_rel.valid = 1'b1;
                            o_rel.bank  = i_cmd.bank;
                        end else begin
                            n_seq = SEQ_BYTES;
                            n_idx = '0;
                        end
                    end
                end
            end
            SEQ_BYTES: begin
                if (can_issue) begin
                    iss             = 1'b1;
                    iss_mem         = 1'b1;
                    iss_res.is_byte = 1'b1;
                    iss_res.last    = last_idx;
                    if (last_idx) begin
                        o_cmd_pop   = 1'b1;
                        o_rel.valid = 1'b1;
                        o_rel.bank  = i_cmd.bank;
                        n_seq       = SEQ_IDLE;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            default: n_seq = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= SEQ_IDLE;
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_seq      <= n_seq;
            r_idx      <= n_idx;
            r_s1_valid <= iss;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_mem <= iss_mem;
        r_s1_res <= iss_res;
    end

    // buffer byte comes from the registered read, in the cycle after its issue
    always_comb begin
        s1_out = r_s1_res;
        if (r_s1_mem) begin
            s1_out.out_byte = r_mem_q;
        end
    end

    assign o_empty = (r_ocnt == '0);
    assign o_res   = r_oq[r_or];
    assign opop    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_oq[r_ow] <= s1_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ow   <= '0;
            r_or   <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_s1_valid) begin
                r_ow <= (r_ow == PW'(OUTQ_DEPTH - 1)) ? '0 : r_ow + PW'(1);
            end
            if (opop) begin
                r_or <= (r_or == PW'(OUTQ_DEPTH - 1)) ? '0 : r_or + PW'(1);
            end
            if (r_s1_valid && !opop) begin
                r_ocnt <= r_ocnt + OCW'(1);
            end else if (opop && !r_s1_valid) begin
                r_ocnt <= r_ocnt - OCW'(1);
            end
        end
    end

endmodule

### sv/ini_section_extractor_unit.sv
// INI section extractor, top level. Input bytes are taken one per cycle while the
// command queue has room and, inside the section, the line bank being filled is free.
// After its terminator beat, a content line's results pass the command queue, the
// issue register and the result queue, the held terminator (if any) first, then one
// per cycle while the result queue has room; a done result takes the same path.
// Reset is synchronous, active low: control and config clear, buffer and data do not.
module ini_section_extractor_unit import ise_pkg::*; #(
    parameter int LINE_MAX = LINE_MAX_DEF,
    parameter int NAME_MAX = NAME_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_marker,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_is_byte,
    output logic        o_is_done,
    output logic [1:0]  o_status,
    output logic        o_last
);

    t_wr  wr;
    t_rel rel;
    t_cmd cmd_in, cmd_head;
    logic cmd_push, cmd_pop, cmdq_full, cmd_valid;
    t_res res;

    assign o_cfg_ready = 1'b1;

    ise_front #(
        .LINE_MAX (LINE_MAX),
        .NAME_MAX (NAME_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .o_full       (full),
        .i_data_byte  (i_data_byte),
        .i_end_marker (i_end_marker),
        .i_cmdq_full  (cmdq_full),
        .i_rel        (rel),
        .o_wr         (wr),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    ise_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmdq_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_head)
    );

    ise_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .o_rel       (rel),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (res)
    );

    assign o_out_byte = res.out_byte;
    assign o_is_byte  = res.is_byte;
    assign o_is_done  = res.is_done;
    assign o_status   = res.status;
    assign o_last     = res.last;

endmodule

### verif/ini_section_extractor_unit_tb.sv
// Testbench for ini_section_extractor_unit: one long INI-style byte stream is
// pushed in, every content beat and the closing status beat are predicted and checked.
// Depends on ise_pkg and the ini_section_extractor_unit RTL.
module ini_section_extractor_unit_tb import ise_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL    = 480;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int FILL_LIMIT   = 1023;

    typedef logic [7:0] t_bytes [$];

    // Tracks the extractor state and holds the result beats still owed.
    class extract_tracker;
        logic [63:0] name_bytes;
        logic [3:0]  name_len;
        t_mode       mode;
        logic [7:0]  line_buf [LINE_MAX_DEF];
        int          fill;
        bit          lead_bracket;
        bit          name_match;
        bit          too_long;
        bit          term_held;
        logic [7:0]  prev_byte;
        logic [7:0]  held_term;
        t_res        owed_beats [$];
        int          mismatches;

        function new();
            name_bytes = '0;
            name_len   = 4'd1;
            mode       = MODE_SEARCH;
            prev_byte  = CH_NUL;
            held_term  = CH_NUL;
            term_held  = 1'b0;
            mismatches = 0;
            start_line();
        endfunction

        function void start_line();
            fill         = 0;
            lead_bracket = 1'b0;
            too_long     = 1'b0;
            name_match   = 1'b1;
        endfunction

        function void set_reg(logic idx, logic [63:0] val);
            if (idx == CFG_IDX_NAME_BYTES) begin
                name_bytes = val;
            end else begin
                name_len = val[3:0];
            end
        endfunction

        // name length as matched: capped, cut at the first zero byte
        function int eff_len();
            int n;
            n = (name_len > NAME_MAX_DEF) ? NAME_MAX_DEF : int'(name_len);
            for (int i = 0; i < n; i++) begin
                if (name_bytes[8*i +: 8] == CH_NUL) return i;
            end
            return n;
        endfunction

        function void owe(logic [7:0] b, logic isb, logic done, logic [1:0] st);
            t_res r;
            r.out_byte = b;
            r.is_byte  = isb;
            r.is_done  = done;
            r.status   = st;
            r.last     = 1'b0;
            owed_beats.push_back(r);
        endfunction

        function void close(logic [1:0] st);
            mode = MODE_DONE;
            owe(CH_NUL, 1'b0, 1'b1, st);
        endfunction

        function void note_input(logic [7:0] b, logic eof);
            int n;
            int start_cnt;
            bit hdr;
            start_cnt = owed_beats.size();
            if (mode == MODE_DONE) return;
            n = eff_len();
            if (eof) begin
                close(mode == MODE_SEARCH ? ST_NOT_FOUND : ST_FOUND);
            end else if (b != CH_NL && b != CH_NUL) begin
                if (fill == 0) lead_bracket = (b == CH_LBR);
                if (mode == MODE_SEARCH) begin
                    if (fill >= 1 && fill <= n && b != name_bytes[8*(fill-1) +: 8])
                        name_match = 1'b0;
                end else if (fill < LINE_MAX_DEF) begin
                    line_buf[fill] = b;
                end else begin
                    too_long = 1'b1;
                end
                if (fill < FILL_LIMIT) fill++;
                prev_byte = b;
            end else begin
                hdr = lead_bracket && prev_byte == CH_RBR;
                if (mode == MODE_SEARCH) begin
                    if (hdr && n >= 1 && name_match && fill == n + 2) begin
                        mode      = MODE_COPY;
                        term_held = 1'b0;
                    end
                end else if (hdr) begin
                    close(ST_FOUND);
                end else if (too_long) begin
                    close(ST_TOO_LONG);
                end else begin
                    // previous terminator goes out only once this line is complete
                    if (term_held) owe(held_term, 1'b1, 1'b0, '0);
                    for (int i = 0; i < fill && i < LINE_MAX_DEF; i++)
                        owe(line_buf[i], 1'b1, 1'b0, '0);
                    held_term = b;
                    term_held = 1'b1;
                end
                start_line();
            end
            if (owed_beats.size() > start_cnt)
                owed_beats[owed_beats.size()-1].last = 1'b1;
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (owed_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat: byte=%02h is_byte=%0b",
                             $time, got.out_byte, got.is_byte,
                             " is_done=%0b status=%0d last=%0b",
                             got.is_done, got.status, got.last);
                return;
            end
            want = owed_beats.pop_front();
            if (got.out_byte !== want.out_byte || got.is_byte !== want.is_byte ||
                got.is_done !== want.is_done || got.status !== want.status ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result mismatch: expected byte=%02h is_byte=%0b",
                             $time, want.out_byte, want.is_byte,
                             " is_done=%0b status=%0d last=%0b",
                             want.is_done, want.status, want.last,
                             " / got byte=%02h is_byte=%0b is_done=%0b status=%0d last=%0b",
                             got.out_byte, got.is_byte, got.is_done, got.status, got.last);
            end
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index  = CFG_IDX_NAME_BYTES;
    logic [63:0] i_cfg_data   = '0;
    logic        push         = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte  = '0;
    logic        i_end_marker = 1'b0;
    logic        empty;
    logic        pop          = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_is_byte;
    logic        o_is_done;
    logic [1:0]  o_status;
    logic        o_last;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int items_sent     = 0;

    extract_tracker tracker = new();

    ini_section_extractor_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_data_byte  (i_data_byte),
        .i_end_marker (i_end_marker),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_is_byte    (o_is_byte),
        .o_is_done    (o_is_done),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #400_000;
        $display("ini_section_extractor_unit_tb: FAIL");
        $finish;
    end

    // result side: pop decided at the falling edge, beat taken at the rising edge
    initial begin : result_side
        t_res got;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
            @(posedge i_clk);
            if (pop === 1'b1 && empty === 1'b0) begin
                got = {o_out_byte, o_is_byte, o_is_done, o_status, o_last};
                tracker.check_result(got);
            end
        end
    end

    function automatic logic [7:0] text_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(1, 255)); while (v == CH_NL);
        return v;
    endfunction

    function automatic logic [7:0] terminator();
        return $urandom_range(0, 1) ? CH_NL : CH_NUL;
    endfunction

    // header hunt lines: noise, near misses of the current name, long lines, empty lines
    function automatic t_bytes search_line();
        t_bytes q;
        int     n;
        int     pick;
        n = tracker.eff_len();
        case ($urandom_range(0, 5))
            0: begin
                repeat ($urandom_range(0, 12)) q.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
                q.push_back(CH_LBR);
                for (int i = 0; i < n; i++) q.push_back(tracker.name_bytes[8*i +: 8]);
                if (n > 0) begin
                    pick    = $urandom_range(1, n);
                    q[pick] = q[pick] ^ 8'($urandom_range(1, 255));
                end
                q.push_back(CH_RBR);
            end
            2: begin
                q.push_back(CH_LBR);
                for (int i = 0; i < n; i++) q.push_back(tracker.name_bytes[8*i +: 8]);
                if (n > 0 && $urandom_range(0, 1) == 1) begin
                    void'(q.pop_back());
                end else begin
                    q.push_back(text_byte());
                end
                q.push_back(CH_RBR);
            end
            3: begin
                // leading blank before the bracket, or closing bracket missing
                pick = $urandom_range(0, 1);
                if (pick == 1) q.push_back(" ");
                q.push_back(CH_LBR);
                for (int i = 0; i < n; i++) q.push_back(tracker.name_bytes[8*i +: 8]);
                if (pick == 1) q.push_back(CH_RBR);
            end
            4: begin
                pick = $urandom_range(LINE_MAX_DEF + 1, 100);
                repeat (pick) q.push_back(text_byte());
                if ($urandom_range(0, 1) == 1) begin
                    q[0]      = CH_LBR;
                    q[pick-1] = CH_RBR;
                end
            end
            default: ;
        endcase
        q.push_back(terminator());
        return q;
    endfunction

    // section body line that never looks like a header and fits the buffer
    function automatic t_bytes content_line();
        t_bytes q;
        int     len;
        int     pick;
        pick = $urandom_range(0, 19);
        if (pick < 3) len = 0;
        else if (pick < 13) len = $urandom_range(1, 8);
        else if (pick < 18) len = $urandom_range(9, 40);
        else len = (pick == 18) ? LINE_MAX_DEF : $urandom_range(41, LINE_MAX_DEF);
        repeat (len) q.push_back(text_byte());
        if (len > 0 && $urandom_range(0, 5) == 0) q[0] = CH_LBR;
        if (len > 1 && $urandom_range(0, 5) == 0) q[len-1] = CH_RBR;
        if (len > 0 && q[0] == CH_LBR && q[len-1] == CH_RBR) q[len-1] = CH_LBR;
        q.push_back(terminator());
        return q;
    endfunction

    task automatic send_item(input logic [7:0] b, input logic eof);
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push         <= 1'b1;
        i_data_byte  <= b;
        i_end_marker <= eof;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        tracker.note_input(b, eof);
        items_sent++;
    endtask

    task automatic send_line(input t_bytes q);
        foreach (q[i]) send_item(q[i], 1'b0);
    endtask

    // stop offering, let every owed beat drain, then allow for zero-result work
    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (tracker.owed_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        tracker.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // upper bits of the length beat are junk on purpose
    task automatic write_name(input logic [63:0] bytes, input logic [3:0] len);
        write_reg(CFG_IDX_NAME_BYTES, bytes);
        write_reg(CFG_IDX_NAME_LENGTH, {32'($urandom), 28'($urandom), len});
    endtask

    task automatic set_idling(input int snd, input int rcv);
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
    endtask

    initial begin : stimulus
        t_bytes      q;
        logic [63:0] nm;
        int          ln;
        int          kind;
        int          goal;
        int          copy_from;
        bit          empty_section;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset name is a zero byte: even "[]" must not open a section
        send_line('{CH_LBR, CH_RBR, CH_NL});
        settle();
        write_name(64'h6261, 4'd2);
        send_line('{8'hFF, CH_RBR, CH_NL});
        send_line('{CH_LBR, "a", "b", CH_RBR, CH_RBR, CH_NUL});
        send_line('{CH_LBR, "a", CH_RBR, CH_NL});
        send_line('{CH_LBR, "a", "c", CH_RBR, CH_NL});

        // header hunt under extreme name settings
        for (int ph = 1; ph <= 3; ph++) begin
            settle();
            case (ph)
                1: begin
                    write_name({64{1'b1}}, 4'd8);
                    set_idling(70, 0);
                end
                2: begin
                    write_name('0, 4'd0);
                    set_idling(0, 70);
                end
                default: begin
                    for (int i = 0; i < 8; i++) nm[8*i +: 8] = text_byte();
                    write_name(nm, 4'd15);
                    set_idling(9, 9);
                end
            endcase
            goal = items_sent + 50;
            while (items_sent < goal && tracker.mode == MODE_SEARCH) send_line(search_line());
        end

        // open the section: plain name, overlong length, or name cut by a zero byte
        if (tracker.mode == MODE_SEARCH) begin
            settle();
            set_idling(0, 0);
            for (int i = 0; i < 8; i++) nm[8*i +: 8] = text_byte();
            kind = $urandom_range(0, 2);
            if (kind == 0) ln = $urandom_range(1, 8);
            else if (kind == 1) ln = $urandom_range(9, 15);
            else ln = $urandom_range(2, 8);
            if (kind == 2) nm[8*$urandom_range(1, ln - 1) +: 8] = CH_NUL;
            write_name(nm, 4'(ln));
            q = '{CH_LBR};
            for (int i = 0; i < tracker.eff_len(); i++) q.push_back(nm[8*i +: 8]);
            q.push_back(CH_RBR);
            q.push_back(terminator());
            send_line(q);
        end

        empty_section = ($urandom_range(0, 9) == 0);
        copy_from     = items_sent;
        for (int ph = 0; ph < 4 && !empty_section; ph++) begin
            settle();
            write_name({32'($urandom), 32'($urandom)}, 4'($urandom_range(0, 15)));
            case (ph)
                0: set_idling(0, 0);
                1: set_idling(70, 0);
                2: set_idling(0, 70);
                default: set_idling(9, 9);
            endcase
            // long receiver hold-off: input side has to back up
            if (ph == 0) hold_left = HOLD_CYCLES;
            goal = copy_from + (ITEM_GOAL - copy_from) * (ph + 1) / 4;
            while (items_sent < goal && tracker.mode == MODE_COPY) send_line(content_line());
        end

        // how the section ends
        q    = {};
        kind = $urandom_range(0, 4);
        case (kind)
            0: begin
                q.push_back(CH_LBR);
                repeat ($urandom_range(0, 6)) q.push_back(text_byte());
                q.push_back(CH_RBR);
                q.push_back(terminator());
            end
            2: begin
                q.push_back("x");
                repeat (LINE_MAX_DEF + $urandom_range(0, 12)) q.push_back(text_byte());
                q.push_back(terminator());
            end
            3: begin
                // oversized header still closes the section cleanly
                q.push_back(CH_LBR);
                repeat ($urandom_range(62, 75)) q.push_back(text_byte());
                q.push_back(CH_RBR);
                q.push_back(terminator());
            end
            4: begin
                repeat ($urandom_range(1, 70)) q.push_back(text_byte());
            end
            default: ;
        endcase
        send_line(q);
        if (kind == 1 || kind == 4) send_item(8'($urandom), 1'b1);

        // after done everything is dropped, end marker included
        repeat (6) send_item(8'($urandom_range(0, 255)), 1'b0);
        send_item(8'($urandom), 1'b1);
        send_item(CH_NL, 1'b0);
        // an empty section leaves the run short of its item count
        while (items_sent < ITEM_GOAL) send_item(8'($urandom_range(0, 255)), 1'b0);

        settle();
        if (tracker.mismatches == 0) begin
            $display("ini_section_extractor_unit_tb: PASS");
        end else begin
            $display("ini_section_extractor_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
